// ===== design/stack_queue_engine_assert.svh =====
// Assertion macros used by the stack queue engine datapath.
`ifndef STACK_QUEUE_ENGINE_ASSERT_SVH
`define STACK_QUEUE_ENGINE_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define SQE_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define SQE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SQE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/sqe_pkg.sv =====
// Types and constants of the stack queue engine.
package sqe_pkg;

	// Command codes
	localparam logic [2:0] OP_PUSH = 3'd0;
	localparam logic [2:0] OP_LIST = 3'd1;
	localparam logic [2:0] OP_POP  = 3'd2;
	localparam logic [2:0] OP_PEEK = 3'd3;
	localparam logic [2:0] OP_SWAP = 3'd4;

	// Status codes
	localparam logic [2:0] STAT_OK         = 3'd0;
	localparam logic [2:0] STAT_POP_EMPTY  = 3'd1;
	localparam logic [2:0] STAT_PEEK_EMPTY = 3'd2;
	localparam logic [2:0] STAT_SWAP_SHORT = 3'd3;
	localparam logic [2:0] STAT_BAD_ARG    = 3'd4;
	localparam logic [2:0] STAT_FULL       = 3'd5;
	localparam logic [2:0] STAT_HALTED     = 3'd6;

	// Most words a list command gives
	localparam int MAX_RESULTS = 32;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [31:0] push_value;
		logic               arg_ok;
	} sqe_req_t;

	typedef struct packed {
		logic signed [31:0] data_value;
		logic               has_value;
		logic [2:0]         status;
		logic               last;
	} sqe_rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_PEEK_OUT,
		S_SWAP_RDB,
		S_SWAP_WRA,
		S_SWAP_WRB,
		S_LIST_OUT
	} sqe_state_t;

	typedef enum logic [1:0] {
		RD_TOP,
		RD_NEXT,
		RD_WALK
	} sqe_rd_sel_t;

	typedef enum logic [1:0] {
		WR_PUSH,
		WR_SWAP_A,
		WR_SWAP_B
	} sqe_wr_sel_t;

	// Controller to datapath commands
	typedef struct packed {
		logic        take_item;
		logic        mem_rd;
		sqe_rd_sel_t rd_sel;
		logic        mem_wr;
		sqe_wr_sel_t wr_sel;
		logic        push_commit;
		logic        pop_commit;
		logic        set_halt;
		logic        list_start;
		logic        list_step;
		logic        hold_load;
		logic        rsp_load;
		logic [2:0]  rsp_status;
		logic        rsp_has_value;
		logic        rsp_last;
	} sqe_ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic [2:0] op;
		logic       arg_ok;
		logic       halted;
		logic       empty;
		logic       few;
		logic       full;
		logic       out_free;
		logic       list_last;
	} sqe_sts_t;

endpackage

// ===== design/sqe_stream_if.sv =====
// Valid/ready stream channel carrying one payload word.
interface sqe_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== design/sqe_datapath.sv =====
// Datapath of the stack queue engine: entry memory, pointers, response register.
`include "stack_queue_engine_assert.svh"

module sqe_datapath #(
	parameter int DEPTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sqe_pkg::sqe_ctl_t ctl,
	output sqe_pkg::sqe_sts_t sts,
	input  sqe_pkg::sqe_req_t req_payload,
	input  logic             rsp_ready,
	output logic             rsp_valid,
	output sqe_pkg::sqe_rsp_t rsp_payload,
	input  logic             cfg_wr_en,
	input  logic             cfg_wr_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = PTR_W + 1;

	logic [31:0]        mem_q [DEPTH];
	logic [31:0]        rdata_q;
	logic [31:0]        hold_q;
	logic [2:0]         op_q;
	logic [31:0]        value_q;
	logic               ok_q;
	logic [PTR_W-1:0]   top_q;
	logic [CNT_W-1:0]   count_q;
	logic               halted_q;
	logic               queue_mode_q;
	logic [PTR_W-1:0]   walk_q;
	logic [CNT_W-1:0]   remain_q;
	logic               rsp_valid_q;
	sqe_pkg::sqe_rsp_t  rsp_q;

	logic [PTR_W-1:0]   top_next;
	logic [PTR_W-1:0]   top_prev;
	logic [PTR_W-1:0]   walk_next;
	logic [SUM_W-1:0]   tail_sum;
	logic [SUM_W-1:0]   tail_wrap;
	logic               push_bottom;
	logic [PTR_W-1:0]   push_addr;
	logic [PTR_W-1:0]   rd_addr;
	logic [PTR_W-1:0]   wr_addr;
	logic [31:0]        wr_data;
	logic [CNT_W-1:0]   list_len;

	assign top_next  = (top_q == PTR_W'(DEPTH - 1)) ? '0 : top_q + 1'b1;
	assign top_prev  = (top_q == '0) ? PTR_W'(DEPTH - 1) : top_q - 1'b1;
	assign walk_next = (walk_q == PTR_W'(DEPTH - 1)) ? '0 : walk_q + 1'b1;

	// Bottom slot sits count entries below the top, around the ring
	assign tail_sum  = {1'b0, top_q} + SUM_W'(count_q);
	assign tail_wrap = (tail_sum >= SUM_W'(DEPTH)) ? tail_sum - SUM_W'(DEPTH) : tail_sum;

	assign push_bottom = queue_mode_q && (count_q != '0);
	always_comb begin
		if (push_bottom) begin
			push_addr = tail_wrap[PTR_W-1:0];
		end else if (count_q != '0) begin
			push_addr = top_prev;
		end else begin
			push_addr = top_q;
		end
	end

	assign list_len = (32'(count_q) > 32'(sqe_pkg::MAX_RESULTS)) ?
		CNT_W'(sqe_pkg::MAX_RESULTS) : count_q;

	always_comb begin
		case (ctl.rd_sel)
			sqe_pkg::RD_TOP:  rd_addr = top_q;
			sqe_pkg::RD_NEXT: rd_addr = top_next;
			sqe_pkg::RD_WALK: rd_addr = walk_q;
			default:          rd_addr = top_q;
		endcase
	end

	always_comb begin
		case (ctl.wr_sel)
			sqe_pkg::WR_PUSH: begin
				wr_addr = push_addr;
				wr_data = value_q;
			end
			sqe_pkg::WR_SWAP_A: begin
				wr_addr = top_q;
				wr_data = rdata_q;
			end
			sqe_pkg::WR_SWAP_B: begin
				wr_addr = top_next;
				wr_data = hold_q;
			end
			default: begin
				wr_addr = top_q;
				wr_data = value_q;
			end
		endcase
	end

	// Entry memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (ctl.mem_wr) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctl.mem_rd) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take_item) begin
			op_q    <= req_payload.cmd;
			value_q <= req_payload.push_value;
			ok_q    <= req_payload.arg_ok;
		end
		if (ctl.hold_load) begin
			hold_q <= rdata_q;
		end
		if (ctl.rsp_load) begin
			rsp_q.data_value <= ctl.rsp_has_value ? rdata_q : '0;
			rsp_q.has_value  <= ctl.rsp_has_value;
			rsp_q.status     <= ctl.rsp_status;
			rsp_q.last       <= ctl.rsp_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q        <= '0;
			count_q      <= '0;
			halted_q     <= 1'b0;
			queue_mode_q <= 1'b0;
			walk_q       <= '0;
			remain_q     <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				queue_mode_q <= cfg_wr_data;
			end
			if (ctl.set_halt) begin
				halted_q <= 1'b1;
			end
			if (ctl.push_commit) begin
				count_q <= count_q + 1'b1;
				if (!push_bottom) begin
					top_q <= push_addr;
				end
			end
			if (ctl.pop_commit) begin
				count_q <= count_q - 1'b1;
				// Drained: restart at slot zero
				top_q   <= (count_q == CNT_W'(1)) ? '0 : top_next;
			end
			if (ctl.list_start) begin
				walk_q   <= top_next;
				remain_q <= list_len;
			end
			if (ctl.list_step) begin
				walk_q   <= walk_next;
				remain_q <= remain_q - 1'b1;
			end
			if (ctl.rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign rsp_payload = rsp_q;

	assign sts.op        = op_q;
	assign sts.arg_ok    = ok_q;
	assign sts.halted    = halted_q;
	assign sts.empty     = (count_q == '0);
	assign sts.few       = (count_q < CNT_W'(2));
	assign sts.full      = (count_q >= CNT_W'(DEPTH));
	assign sts.out_free  = !rsp_valid_q || rsp_ready;
	assign sts.list_last = (remain_q == CNT_W'(1));

	`SQE_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_W'(DEPTH), "count above depth")
	`SQE_ASSERT_IMPL(a_empty_top_zero, clk, arst_n, count_q == '0, top_q == '0, "empty, top moved")
	`SQE_ASSERT_IMPL(a_no_overwrite, clk, arst_n, ctl.rsp_load, !rsp_valid_q || rsp_ready, "rsp lost")
	`SQE_ASSERT_NEXT(a_halt_sticky, clk, arst_n, halted_q, halted_q, "halt flag cleared")
	`SQE_ASSERT_IMPL(a_no_write_halted, clk, arst_n, ctl.mem_wr, !halted_q, "write while halted")

endmodule

// ===== design/sqe_controller.sv =====
// Command sequencer of the stack queue engine.
module sqe_controller (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  sqe_pkg::sqe_sts_t sts,
	output sqe_pkg::sqe_ctl_t ctl
);

	sqe_pkg::sqe_state_t state_q;
	sqe_pkg::sqe_state_t state_next;

	logic [2:0]          dec_status;
	logic                dec_err;
	logic                dec_rd;
	sqe_pkg::sqe_state_t dec_next;

	// Decode the held command against the stack status
	always_comb begin
		dec_status = sqe_pkg::STAT_OK;
		dec_err    = 1'b0;
		dec_rd     = 1'b0;
		dec_next   = sqe_pkg::S_IDLE;
		if (sts.halted) begin
			dec_status = sqe_pkg::STAT_HALTED;
		end else begin
			case (sts.op)
				sqe_pkg::OP_PUSH: begin
					if (sts.full) begin
						dec_err    = 1'b1;
						dec_status = sqe_pkg::STAT_FULL;
					end else if (!sts.arg_ok) begin
						dec_err    = 1'b1;
						dec_status = sqe_pkg::STAT_BAD_ARG;
					end
				end
				sqe_pkg::OP_LIST: begin
					if (!sts.empty) begin
						dec_rd   = 1'b1;
						dec_next = sqe_pkg::S_LIST_OUT;
					end
				end
				sqe_pkg::OP_POP: begin
					if (sts.empty) begin
						dec_err    = 1'b1;
						dec_status = sqe_pkg::STAT_POP_EMPTY;
					end
				end
				sqe_pkg::OP_PEEK: begin
					if (sts.empty) begin
						dec_err    = 1'b1;
						dec_status = sqe_pkg::STAT_PEEK_EMPTY;
					end else begin
						dec_rd   = 1'b1;
						dec_next = sqe_pkg::S_PEEK_OUT;
					end
				end
				sqe_pkg::OP_SWAP: begin
					if (sts.few) begin
						dec_err    = 1'b1;
						dec_status = sqe_pkg::STAT_SWAP_SHORT;
					end else begin
						dec_rd   = 1'b1;
						dec_next = sqe_pkg::S_SWAP_RDB;
					end
				end
				default: begin
					dec_err    = 1'b1;
					dec_status = sqe_pkg::STAT_BAD_ARG;
				end
			endcase
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			sqe_pkg::S_IDLE: begin
				if (req_valid) begin
					state_next = sqe_pkg::S_EXEC;
				end
			end
			sqe_pkg::S_EXEC: begin
				if (dec_rd) begin
					state_next = dec_next;
				end else if (sts.out_free) begin
					state_next = sqe_pkg::S_IDLE;
				end
			end
			sqe_pkg::S_PEEK_OUT: begin
				if (sts.out_free) begin
					state_next = sqe_pkg::S_IDLE;
				end
			end
			sqe_pkg::S_SWAP_RDB: state_next = sqe_pkg::S_SWAP_WRA;
			sqe_pkg::S_SWAP_WRA: state_next = sqe_pkg::S_SWAP_WRB;
			sqe_pkg::S_SWAP_WRB: begin
				if (sts.out_free) begin
					state_next = sqe_pkg::S_IDLE;
				end
			end
			sqe_pkg::S_LIST_OUT: begin
				if (sts.out_free && sts.list_last) begin
					state_next = sqe_pkg::S_IDLE;
				end
			end
			default: state_next = sqe_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctl               = '0;
		ctl.rd_sel        = sqe_pkg::RD_TOP;
		ctl.wr_sel        = sqe_pkg::WR_PUSH;
		ctl.rsp_status    = sqe_pkg::STAT_OK;
		ctl.rsp_last      = 1'b1;
		req_ready         = 1'b0;
		case (state_q)
			sqe_pkg::S_IDLE: begin
				req_ready     = 1'b1;
				ctl.take_item = req_valid;
			end
			sqe_pkg::S_EXEC: begin
				if (dec_rd) begin
					ctl.mem_rd     = 1'b1;
					ctl.rd_sel     = sqe_pkg::RD_TOP;
					ctl.list_start = (sts.op == sqe_pkg::OP_LIST);
				end else if (sts.out_free) begin
					ctl.rsp_load   = 1'b1;
					ctl.rsp_status = dec_status;
					ctl.set_halt   = dec_err;
					if (!sts.halted && !dec_err) begin
						ctl.push_commit = (sts.op == sqe_pkg::OP_PUSH);
						ctl.mem_wr      = (sts.op == sqe_pkg::OP_PUSH);
						ctl.pop_commit  = (sts.op == sqe_pkg::OP_POP);
					end
				end
			end
			sqe_pkg::S_PEEK_OUT: begin
				ctl.rsp_load      = sts.out_free;
				ctl.rsp_has_value = 1'b1;
			end
			sqe_pkg::S_SWAP_RDB: begin
				ctl.mem_rd    = 1'b1;
				ctl.rd_sel    = sqe_pkg::RD_NEXT;
				ctl.hold_load = 1'b1;
			end
			sqe_pkg::S_SWAP_WRA: begin
				ctl.mem_wr = 1'b1;
				ctl.wr_sel = sqe_pkg::WR_SWAP_A;
			end
			sqe_pkg::S_SWAP_WRB: begin
				ctl.mem_wr   = sts.out_free;
				ctl.wr_sel   = sqe_pkg::WR_SWAP_B;
				ctl.rsp_load = sts.out_free;
			end
			sqe_pkg::S_LIST_OUT: begin
				ctl.rsp_load      = sts.out_free;
				ctl.rsp_has_value = 1'b1;
				ctl.rsp_last      = sts.list_last;
				ctl.list_step     = sts.out_free;
				ctl.mem_rd        = sts.out_free;
				ctl.rd_sel        = sqe_pkg::RD_WALK;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sqe_pkg::S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

// ===== design/stack_queue_engine.sv =====
// Top level of the stack queue engine: controller plus datapath.
//
// The request channel takes one command word (cmd, push_value, arg_ok); the
// response channel gives result words (data_value, has_value, status, last).
// Push, pop, peek and swap give one word with last set; list gives one word
// per entry from top to bottom, at most MAX_RESULTS, last set on the final one,
// or a single word with no value when the stack is empty.
// The sequencer takes a command only in its idle state and runs it through
// its states: push, pop and any error load the word in the execute state;
// peek reads the top, then loads it; swap reads the top and the next entry,
// writes both back exchanged (two reads, two writes), loading its word with
// the last write; list reads the top, then loads one word per entry.
// The response sits in an output register; the next command is accepted
// while it waits, and the sequencer holds only when it must load a new word.
// A stalled receiver holds the response word and the sequencer.
// Reset clears the pointers, count, halt flag and queue_mode; entry contents
// are left as they are and are never read before they are written.
// cfg_wr_en/cfg_wr_data set queue_mode; write it only while idle.
// After the first error every command answers with the halted status.
module stack_queue_engine #(
	parameter int DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	sqe_stream_if.sink   request,
	sqe_stream_if.source response,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data
);

	sqe_pkg::sqe_ctl_t ctl;
	sqe_pkg::sqe_sts_t sts;
	sqe_pkg::sqe_req_t req_word;
	sqe_pkg::sqe_rsp_t rsp_word;
	logic              req_ready;
	logic              rsp_valid;

	assign req_word         = request.payload;
	assign request.ready    = req_ready;
	assign response.valid   = rsp_valid;
	assign response.payload = rsp_word;

	sqe_controller u_controller (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.req_ready (req_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	sqe_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.req_payload (req_word),
		.rsp_ready   (response.ready),
		.rsp_valid   (rsp_valid),
		.rsp_payload (rsp_word),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

endmodule
